### sv/npps_pkg.sv
// Shared constants and controller/datapath interface types for the nearest path point search.
`default_nettype none

package npps_pkg;

   localparam int PATH_DEPTH_DEFAULT  = 1024;
   localparam int COORD_WIDTH_DEFAULT = 16;

   localparam int PATH_LEN_W = 11;
   localparam int REQ_IDX_W  = 10;
   localparam int RSP_IDX_W  = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic REG_PATH_LENGTH = 1'b0;

   typedef struct packed {
      logic load;
      logic capture;
      logic issue;
   } npps_cmd_type;

   typedef struct packed {
      logic len_zero;
      logic last_issue;
      logic pipe_empty;
   } npps_status_type;

endpackage

`default_nettype wire

### sv/npps_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module npps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/npps_ctrl.sv
// Controller state machine that sequences loads, the store scan and the result strobe.
`default_nettype none

module npps_ctrl import npps_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic            operation,
   input  wire npps_status_type status,
   output logic                 busy,
   output logic                 rsp_valid,
   output npps_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_REPLY = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_REPLY);
   assign accept    = start && !busy;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.capture = 1'b0;
      cmd.issue   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (operation == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = status.len_zero ? S_REPLY : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_reply_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_reply_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status.pipe_empty)
      else $error("result strobed while the distance pipeline still held entries");

endmodule

`default_nettype wire

### sv/npps_dpath.sv
// Datapath: path store, scan address counter, squared distance pipeline and running minimum.
`default_nettype none

module npps_dpath import npps_pkg::*; #(
   parameter int PATH_DEPTH  = PATH_DEPTH_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire npps_cmd_type           cmd,
   input  wire logic [PATH_LEN_W-1:0]  path_length,
   input  wire logic [REQ_IDX_W-1:0]   point_index,
   input  wire logic [COORD_WIDTH-1:0] coord_x,
   input  wire logic [COORD_WIDTH-1:0] coord_y,
   output npps_status_type             status,
   output logic      [RSP_IDX_W-1:0]   nearest_index
);

   localparam int AW  = $clog2(PATH_DEPTH);
   localparam int CW  = COORD_WIDTH;
   localparam int SQW = 2 * COORD_WIDTH;
   localparam int SMW = 2 * COORD_WIDTH + 1;
   localparam int IW  = (AW > RSP_IDX_W) ? AW : RSP_IDX_W;
   localparam int LW  = ($clog2(PATH_DEPTH + 1) > PATH_LEN_W) ?
                        $clog2(PATH_DEPTH + 1) : PATH_LEN_W;

   logic [CW-1:0]   qx_ff, qy_ff;
   logic [AW-1:0]   addr_ff, last_ff;
   logic [LW-1:0]   len_ext, depth_ext, len_clamp, len_m1;
   logic [IW-1:0]   load_ext, best_ext;
   logic            load_ok;
   logic [AW-1:0]   ram_addr;
   logic [2*CW-1:0] ram_rdata;

   logic            v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AW-1:0]   idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [CW:0]     dx, dy, dx_mag, dy_mag;
   logic [CW-1:0]   ax_ff, ay_ff;
   logic [SQW-1:0]  sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [SMW-1:0]  sum_ff;
   logic            have_best_ff;
   logic [SMW-1:0]  best_sum_ff;
   logic [AW-1:0]   best_idx_ff;
   logic            take;

   assign len_ext   = LW'(path_length);
   assign depth_ext = LW'(PATH_DEPTH);
   assign len_clamp = (len_ext > depth_ext) ? depth_ext : len_ext;
   assign len_m1    = len_clamp - 1'b1;

   assign load_ext = IW'(point_index);
   assign load_ok  = (32'(point_index) < 32'(PATH_DEPTH));
   assign ram_addr = cmd.load ? load_ext[AW-1:0] : addr_ff;

   npps_ram #(
      .WIDTH (2 * CW),
      .DEPTH (PATH_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.load && load_ok),
      .addr  (ram_addr),
      .wdata ({coord_x, coord_y}),
      .rdata (ram_rdata)
   );

   assign dx     = {ram_rdata[2*CW-1], ram_rdata[2*CW-1:CW]} - {qx_ff[CW-1], qx_ff};
   assign dy     = {ram_rdata[CW-1], ram_rdata[CW-1:0]} - {qy_ff[CW-1], qy_ff};
   assign dx_mag = dx[CW] ? (~dx + 1'b1) : dx;
   assign dy_mag = dy[CW] ? (~dy + 1'b1) : dy;
   assign sqx_in = ax_ff * ax_ff;
   assign sqy_in = ay_ff * ay_ff;
   assign take   = v4_ff && (!have_best_ff || (sum_ff < best_sum_ff));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qx_ff   <= coord_x;
         qy_ff   <= coord_y;
         addr_ff <= '0;
         last_ff <= len_m1[AW-1:0];
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + 1'b1;
      end
      idx1_ff <= addr_ff;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      ax_ff   <= dx_mag[CW-1:0];
      ay_ff   <= dy_mag[CW-1:0];
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      sum_ff  <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      if (cmd.capture) begin
         best_idx_ff <= '0;
      end else if (take) begin
         best_idx_ff <= idx4_ff;
         best_sum_ff <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (cmd.capture) begin
            have_best_ff <= 1'b0;
         end else if (v4_ff) begin
            have_best_ff <= 1'b1;
         end
      end
   end

   assign status.len_zero   = (path_length == '0);
   assign status.last_issue = (addr_ff == last_ff);
   assign status.pipe_empty = !(v1_ff || v2_ff || v3_ff || v4_ff);

   assign best_ext      = IW'(best_idx_ff);
   assign nearest_index = best_ext[RSP_IDX_W-1:0];

   a_issue_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> v1_ff)
      else $error("issued store read did not enter the distance pipeline");

   a_compare_seeds_best: assert property (@(posedge clock) disable iff (reset)
      v4_ff |=> have_best_ff)
      else $error("compared distance left no running minimum");

endmodule

`default_nettype wire

### sv/nearest_path_point_search.sv
// Top level: a start asserted while busy is low transfers one item. A load writes one path point
// into the store, with busy staying low. A query walks stored entries 0 to n-1 through the
// single read port of the path store, one entry per cycle, where n is path_length clamped to
// PATH_DEPTH; busy is high throughout, rsp_valid pulses for one cycle once the scan has drained
// (in the cycle after the query transfer for an empty path), and the next item can transfer
// once busy is low again. The result is not held: the receiver must take it in the cycle that
// rsp_valid is high. The store holds no reset value, so a query must only reach entries that
// were loaded. path_length is written through the APB port at byte address 0. The user must
// write it only while the block is idle; the block does not enforce it.
`default_nettype none

module nearest_path_point_search import npps_pkg::*; #(
   parameter int PATH_DEPTH  = PATH_DEPTH_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_operation,
   input  wire logic [REQ_IDX_W-1:0]   req_point_index,
   input  wire logic [COORD_WIDTH-1:0] req_coord_x,
   input  wire logic [COORD_WIDTH-1:0] req_coord_y,
   output logic                        rsp_valid,
   output logic      [RSP_IDX_W-1:0]   rsp_nearest_index,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic      [CSR_DATA_W-1:0]  prdata,
   output logic                        pready
);

   logic [PATH_LEN_W-1:0] path_length_ff;
   logic                  csr_write;
   npps_cmd_type          cmd;
   npps_status_type       status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         path_length_ff <= '0;
      end else if (csr_write && (paddr[2] == REG_PATH_LENGTH)) begin
         path_length_ff <= pwdata[PATH_LEN_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_PATH_LENGTH) ? CSR_DATA_W'(path_length_ff) : '0;

   npps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   npps_dpath #(
      .PATH_DEPTH  (PATH_DEPTH),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .path_length   (path_length_ff),
      .point_index   (req_point_index),
      .coord_x       (req_coord_x),
      .coord_y       (req_coord_y),
      .status        (status),
      .nearest_index (rsp_nearest_index)
   );

endmodule

`default_nettype wire

### dv/nearest_path_point_search_tb.sv
// Self-checking testbench for nearest_path_point_search: directed table, then random traffic.
module nearest_path_point_search_tb import npps_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW            = COORD_WIDTH_DEFAULT;
   localparam int DEPTH         = PATH_DEPTH_DEFAULT;
   localparam int ITEM_TARGET   = 580;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 32;
   localparam int MAX_REPORTS   = 40;
   localparam int WATCHDOG_NS   = 100_000_000;

   localparam logic [CSR_ADDR_W-1:0] LEN_ADDR    = CSR_ADDR_W'(4 * REG_PATH_LENGTH);
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4);

   localparam logic [CW-1:0] EDGE_COORDS [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

   typedef enum logic [0:0] {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic                    op;
      logic [REQ_IDX_W-1:0]    index;
      logic [CW-1:0]           x;
      logic [CW-1:0]           y;
      logic [CSR_ADDR_W-1:0]   addr;
      logic [CSR_DATA_W-1:0]   value;
      logic                    typed;
      logic [RSP_IDX_W-1:0]    want;
   } stim_row_type;

   // Rows marked typed carry an answer that is obvious from the stored points; the rest
   // are checked against the predictor.
   localparam stim_row_type DIRECTED [24] = '{
      '{ROW_ITEM, OP_QUERY, 10'h3FF, 16'h0000, 16'h0000, LEN_ADDR, 32'd0, 1'b1, 10'd0},
      '{ROW_ITEM, OP_QUERY, 10'h000, 16'h8000, 16'h7FFF, LEN_ADDR, 32'd0, 1'b1, 10'd0},
      '{ROW_ITEM, OP_LOAD,  10'd0,   16'h7FFF, 16'h7FFF, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_LOAD,  10'd1,   16'h8000, 16'h8000, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_LOAD,  10'd2,   16'h0000, 16'h0000, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_LOAD,  10'd3,   16'h0000, 16'h0000, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_LOAD,  10'h3FF, 16'hFFFF, 16'h0001, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_LOAD,  10'd4,   16'h0100, 16'hFF00, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_CSR,  OP_LOAD,  10'd0,   16'h0000, 16'h0000, LEN_ADDR, 32'd1, 1'b0, 10'd0},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h8000, 16'h8000, LEN_ADDR, 32'd0, 1'b1, 10'd0},
      '{ROW_CSR,  OP_LOAD,  10'd0,   16'h0000, 16'h0000, LEN_ADDR, 32'hFFFF_F804, 1'b0, 10'd0},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h8000, 16'h8000, LEN_ADDR, 32'd0, 1'b1, 10'd1},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h7FFF, 16'h7FFF, LEN_ADDR, 32'd0, 1'b1, 10'd0},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h0000, 16'h0000, LEN_ADDR, 32'd0, 1'b1, 10'd2},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h7FFF, 16'h8000, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_CSR,  OP_LOAD,  10'd0,   16'h0000, 16'h0000, UNUSED_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h0000, 16'h0000, LEN_ADDR, 32'd0, 1'b1, 10'd2},
      '{ROW_CSR,  OP_LOAD,  10'd0,   16'h0000, 16'h0000, LEN_ADDR, 32'd5, 1'b0, 10'd0},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h0100, 16'hFF00, LEN_ADDR, 32'd0, 1'b1, 10'd4},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h0080, 16'hFF80, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_LOAD,  10'd2,   16'h0007, 16'hFFFD, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h0007, 16'hFFFD, LEN_ADDR, 32'd0, 1'b1, 10'd2},
      '{ROW_CSR,  OP_LOAD,  10'd0,   16'h0000, 16'h0000, LEN_ADDR, 32'd0, 1'b0, 10'd0},
      '{ROW_ITEM, OP_QUERY, 10'd0,   16'h0064, 16'h0064, LEN_ADDR, 32'd0, 1'b1, 10'd0}
   };

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_operation;
   logic [REQ_IDX_W-1:0]    req_point_index;
   logic [CW-1:0]           req_coord_x;
   logic [CW-1:0]           req_coord_y;
   logic                    rsp_valid;
   logic [RSP_IDX_W-1:0]    rsp_nearest_index;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   logic signed [CW-1:0]    path_x_mem [DEPTH];
   logic signed [CW-1:0]    path_y_mem [DEPTH];
   bit                      loaded [DEPTH];
   logic [PATH_LEN_W-1:0]   path_len_model;
   logic [RSP_IDX_W-1:0]    nearest_index_q [$];

   int mismatch_count  = 0;
   int load_count      = 0;
   int query_count     = 0;
   int result_count    = 0;
   int csr_write_count = 0;
   int setting_count   = 0;

   nearest_path_point_search uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_point_index   (req_point_index),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .rsp_valid         (rsp_valid),
      .rsp_nearest_index (rsp_nearest_index),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("[%0t] %s: got %0d, wanted %0d", $realtime, what, got, want);
      end
   endtask

   function automatic logic [RSP_IDX_W-1:0] nearest_stored_point(input logic signed [CW-1:0] qx,
                                                                 input logic signed [CW-1:0] qy);
      int     span;
      int     best;
      longint best_dist;
      longint sq_dist;
      longint dx;
      longint dy;
      span = (path_len_model > DEPTH) ? DEPTH : int'(path_len_model);
      best = 0;
      best_dist = 0;
      for (int i = 0; i < span; i++) begin
         dx = longint'(path_x_mem[i]) - longint'(qx);
         dy = longint'(path_y_mem[i]) - longint'(qy);
         sq_dist = dx * dx + dy * dy;
         if (i == 0 || sq_dist < best_dist) begin
            best = i;
            best_dist = sq_dist;
         end
      end
      return best[RSP_IDX_W-1:0];
   endfunction

   function automatic logic [CW-1:0] rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return CW'($urandom);
      if (r < 75) return CW'($urandom_range(0, 16)) - CW'(8);
      if (r < 90) return EDGE_COORDS[$urandom_range(0, 3)];
      return EDGE_COORDS[$urandom_range(0, 3)] ^ CW'($urandom_range(0, 15));
   endfunction

   function automatic int gap_length(input bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic transfer(input logic op, input logic [REQ_IDX_W-1:0] index,
                           input logic [CW-1:0] x, input logic [CW-1:0] y,
                           input logic typed, input logic [RSP_IDX_W-1:0] want);
      start <= 1'b1;
      req_operation <= op;
      req_point_index <= index;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (busy !== 1'b0);
      if (op == OP_QUERY) begin
         nearest_index_q = {nearest_index_q, (typed ? want : nearest_stored_point(x, y))};
         query_count++;
      end else begin
         path_x_mem[index] = x;
         path_y_mem[index] = y;
         loaded[index] = 1'b1;
         load_count++;
      end
   endtask

   task automatic idle_gap(input bit burst);
      int n;
      n = gap_length(burst);
      if (n > 0) begin
         start <= 1'b0;
         req_operation <= 1'($urandom);
         req_point_index <= REQ_IDX_W'($urandom);
         req_coord_x <= CW'($urandom);
         req_coord_y <= CW'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (nearest_index_q.size() != 0 || busy !== 1'b0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A register write followed back to back by a read of path_length.
   task automatic csr_write_and_verify(input logic [CSR_ADDR_W-1:0] addr,
                                       input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == LEN_ADDR) begin
         path_len_model = value[PATH_LEN_W-1:0];
         setting_count++;
      end
      csr_write_count++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= LEN_ADDR;
      pwdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== CSR_DATA_W'(path_len_model)) begin
         report_mismatch("path_length readback", prdata, CSR_DATA_W'(path_len_model));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic fill_prefix(input int len, input bit burst);
      int span;
      span = (len > DEPTH) ? DEPTH : len;
      for (int i = 0; i < span; i++) begin
         if (!loaded[i]) begin
            transfer(OP_LOAD, REQ_IDX_W'(i), rand_coord(), rand_coord(), 1'b0, '0);
            idle_gap(burst);
         end
      end
   endtask

   task automatic random_item(input int len, input bit burst);
      int top;
      top = (len + 3 > DEPTH - 1) ? DEPTH - 1 : len + 3;
      if ($urandom_range(0, 99) < 50) begin
         transfer(OP_QUERY, REQ_IDX_W'($urandom), rand_coord(), rand_coord(), 1'b0, '0);
      end else if ($urandom_range(0, 99) < 70) begin
         transfer(OP_LOAD, REQ_IDX_W'($urandom_range(0, top)), rand_coord(), rand_coord(),
                  1'b0, '0);
      end else begin
         transfer(OP_LOAD, REQ_IDX_W'($urandom), rand_coord(), rand_coord(), 1'b0, '0);
      end
      idle_gap(burst);
   endtask

   always @(posedge clock) begin : check_results
      logic [RSP_IDX_W-1:0] want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (nearest_index_q.size() == 0) begin
            report_mismatch("result with no query pending", 32'(rsp_nearest_index), 0);
         end else begin
            want = nearest_index_q.pop_front();
            result_count++;
            if (rsp_nearest_index !== want) begin
               report_mismatch("nearest_index", 32'(rsp_nearest_index), 32'(want));
            end
         end
      end
   end

   initial begin : stimulus
      int  len;
      int  r;
      bit  burst;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_LOAD;
      req_point_index = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = LEN_ADDR;
      pwdata = '0;
      path_len_model = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED); i++) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            settle();
            csr_write_and_verify(DIRECTED[i].addr, DIRECTED[i].value);
         end else begin
            transfer(DIRECTED[i].op, DIRECTED[i].index, DIRECTED[i].x, DIRECTED[i].y,
                     DIRECTED[i].typed, DIRECTED[i].want);
            idle_gap(1'b0);
         end
      end

      while (load_count + query_count < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 6) len = 0;
         else if (r < 80) len = $urandom_range(1, 12);
         else len = $urandom_range(13, 64);
         burst = ($urandom_range(0, 3) == 0);
         fill_prefix(len, burst);
         settle();
         if ($urandom_range(0, 99) < 15) begin
            csr_write_and_verify(UNUSED_ADDR, CSR_DATA_W'($urandom));
         end
         if ($urandom_range(0, 99) < 20) begin
            csr_write_and_verify(LEN_ADDR, {21'($urandom), PATH_LEN_W'(len)});
         end else begin
            csr_write_and_verify(LEN_ADDR, CSR_DATA_W'(len));
         end
         repeat ($urandom_range(20, 60)) begin
            if (load_count + query_count < ITEM_TARGET) begin
               random_item(len, burst);
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d loads and %0d queries over %0d path length settings.",
               load_count, query_count, setting_count);
      $display("Checked %0d results and %0d register writes, %0d mismatches.",
               result_count, csr_write_count, mismatch_count);
      if (mismatch_count == 0 && nearest_index_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("Timed out with %0d results still pending.", nearest_index_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
sv/npps_pkg.sv
sv/npps_ram.sv
sv/npps_ctrl.sv
sv/npps_dpath.sv
sv/nearest_path_point_search.sv
dv/nearest_path_point_search_tb.sv
